// ===== hw/rtl/ascii_report_frame_parser_macros.svh =====
// assertion macros shared by the checker of the report frame parser
`ifndef ASCII_REPORT_FRAME_PARSER_MACROS_SVH
`define ASCII_REPORT_FRAME_PARSER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ARFP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("arfp assertion failed");

// next-cycle implication, disabled while reset is high
`define ARFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("arfp assertion failed");

`endif

// ===== hw/rtl/arfp_pkg.sv =====
// types and constants of the report frame parser
package arfp_pkg;

   localparam int ACC_W   = 14;
   localparam int ADDR_W  = 24;
   localparam int TYPE_W  = 7;
   localparam int ERR_W   = 7;
   localparam int POWER_W = 8;
   localparam int COUNT_W = 5;
   localparam int INDEX_W = 4;

   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_NINE       = 8'h39;
   localparam logic [7:0] CMD_REPORT_CHAR = 8'h31;
   localparam int         DECIMAL_BASE    = 10;
   localparam int         REPORT_FIXED_LEN = 7;

   localparam int QUEUE_DEPTH = 4;

   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_VALUE  = 1'b1;

   typedef enum logic [2:0] {
      TAG_START,
      TAG_ADDR,
      TAG_LEN,
      TAG_TYPE,
      TAG_ERR,
      TAG_POW,
      TAG_VAL
   } tag_type;

   // one classified byte handed from the front to the back
   typedef struct packed {
      tag_type    tag;
      logic       first;
      logic       fin;
      logic [7:0] data;
   } entry_type;

endpackage

// ===== hw/rtl/arfp_if.sv =====
// handshake channels of the report frame parser
interface arfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       frame_start;

   modport source (output valid, output in_byte, output frame_start, input ready);
   modport sink (input valid, input in_byte, input frame_start, output ready);
endinterface

interface arfp_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [23:0] sensor_address;
   logic [6:0]  device_type;
   logic [6:0]  error_code;
   logic [7:0]  power_level;
   logic [4:0]  value_count;
   logic [13:0] sample_value;
   logic [3:0]  sample_index;
   logic        last;

   modport source (
      output valid, output result_kind, output sensor_address, output device_type,
      output error_code, output power_level, output value_count, output sample_value,
      output sample_index, output last, input ready
   );
   modport sink (
      input valid, input result_kind, input sensor_address, input device_type,
      input error_code, input power_level, input value_count, input sample_value,
      input sample_index, input last, output ready
   );
endinterface

// ===== hw/rtl/arfp_front.sv =====
// front end: tracks the byte position and tags each byte with its field
module arfp_front #(
   parameter int ADDRESS_BYTES = 3,
   parameter int VALUE_DIGITS  = 4
) (
   input  logic                clock,
   input  logic                reset,
   arfp_req_if.sink            req_ch,
   input  logic                q_full,
   output logic                q_push,
   output arfp_pkg::entry_type q_entry
);
   import arfp_pkg::*;

   localparam int POS_ADDR = 1;
   localparam int POS_CMD  = POS_ADDR + ADDRESS_BYTES;
   localparam int POS_LEN  = POS_CMD + 2;
   localparam int POS_TYPE = POS_LEN + 4;
   localparam int POS_ERR  = POS_TYPE + 2;
   localparam int POS_POW  = POS_ERR + 2;
   localparam int POS_VAL  = POS_POW + 3;
   localparam int POS_END  = POS_VAL + VALUE_DIGITS - 1;
   localparam int POS_W    = $clog2(POS_END + 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             accept;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;

   always_comb begin
      pos_in        = pos_ff;
      q_push        = 1'b0;
      q_entry.tag   = TAG_ADDR;
      q_entry.first = 1'b0;
      q_entry.fin   = 1'b0;
      q_entry.data  = req_ch.in_byte;
      if (accept) begin
         if (req_ch.frame_start) begin
            q_push      = 1'b1;
            q_entry.tag = TAG_START;
            pos_in      = POS_W'(POS_ADDR);
         end else if (pos_ff == '0) begin
            pos_in = '0;
         end else if (pos_ff < POS_W'(POS_CMD)) begin
            q_push = 1'b1;
            pos_in = pos_ff + 1'b1;
         end else if (pos_ff == POS_W'(POS_CMD)) begin
            pos_in = pos_ff + 1'b1;
         end else if (pos_ff == POS_W'(POS_CMD + 1)) begin
            // only report frames go on
            pos_in = (req_ch.in_byte == CMD_REPORT_CHAR) ? pos_ff + 1'b1 : '0;
         end else if (pos_ff < POS_W'(POS_TYPE)) begin
            q_push        = 1'b1;
            q_entry.tag   = TAG_LEN;
            q_entry.first = (pos_ff == POS_W'(POS_LEN));
            q_entry.fin   = (pos_ff == POS_W'(POS_TYPE - 1));
            pos_in        = pos_ff + 1'b1;
         end else if (pos_ff < POS_W'(POS_ERR)) begin
            q_push        = 1'b1;
            q_entry.tag   = TAG_TYPE;
            q_entry.first = (pos_ff == POS_W'(POS_TYPE));
            q_entry.fin   = (pos_ff == POS_W'(POS_ERR - 1));
            pos_in        = pos_ff + 1'b1;
         end else if (pos_ff < POS_W'(POS_POW)) begin
            q_push        = 1'b1;
            q_entry.tag   = TAG_ERR;
            q_entry.first = (pos_ff == POS_W'(POS_ERR));
            q_entry.fin   = (pos_ff == POS_W'(POS_POW - 1));
            pos_in        = pos_ff + 1'b1;
         end else if (pos_ff < POS_W'(POS_VAL)) begin
            q_push        = 1'b1;
            q_entry.tag   = TAG_POW;
            q_entry.first = (pos_ff == POS_W'(POS_POW));
            q_entry.fin   = (pos_ff == POS_W'(POS_VAL - 1));
            pos_in        = pos_ff + 1'b1;
         end else begin
            // value section cycles; the back end decides where the frame ends
            q_push        = 1'b1;
            q_entry.tag   = TAG_VAL;
            q_entry.first = (pos_ff == POS_W'(POS_VAL));
            q_entry.fin   = (pos_ff == POS_W'(POS_END));
            pos_in        = q_entry.fin ? POS_W'(POS_VAL) : pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== hw/rtl/arfp_queue.sv =====
// short queue of tagged bytes between front and back
module arfp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  arfp_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output arfp_pkg::entry_type pop_entry
);
   import arfp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/arfp_back.sv =====
// back end: decimal conversion, field stores and the result register
module arfp_back #(
   parameter int MAX_VALUES   = 16,
   parameter int VALUE_DIGITS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  arfp_pkg::entry_type q_entry,
   output logic                q_pop,
   arfp_rsp_if.source          rsp_ch
);
   import arfp_pkg::*;

   localparam int CNT_W   = $clog2(MAX_VALUES + 1);
   localparam int CAP     = MAX_VALUES * VALUE_DIGITS;
   localparam int X_W     = $clog2(CAP + 1);
   localparam int SHIFT   = 16;
   localparam int RECIP   = ((1 << SHIFT) + VALUE_DIGITS - 1) / VALUE_DIGITS;
   localparam int RECIP_W = SHIFT + 1;
   localparam int PROD_W  = X_W + RECIP_W;

   logic              active_ff, active_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              stop_ff, stop_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ACC_W-1:0]  len_ff, len_in;
   logic [TYPE_W-1:0] type_ff, type_in;
   logic [ERR_W-1:0]  err_ff, err_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [INDEX_W-1:0] vidx_ff, vidx_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              out_valid_ff, out_valid_in;
   logic              kind_ff, kind_in;
   logic [POWER_W-1:0] power_ff, power_in;
   logic [ACC_W-1:0]  sample_ff, sample_in;
   logic [INDEX_W-1:0] sidx_ff, sidx_in;
   logic              last_ff, last_in;

   logic [ACC_W-1:0]  acc_base, acc_new;
   logic              stop_base, stop_new, is_digit;
   logic [7:0]        digit;
   logic [ACC_W-1:0]  len_less;
   logic [X_W-1:0]    x_small;
   logic [PROD_W-1:0] prod;
   logic [CNT_W-1:0]  rem_dec;

   assign q_pop = !q_empty && (!out_valid_ff || rsp_ch.ready);

   // digit step of the current field
   always_comb begin
      acc_base  = q_entry.first ? '0 : acc_ff;
      stop_base = q_entry.first ? 1'b0 : stop_ff;
      is_digit  = (q_entry.data >= CHAR_ZERO) && (q_entry.data <= CHAR_NINE);
      digit     = q_entry.data - CHAR_ZERO;
      if (!stop_base && is_digit) begin
         acc_new  = acc_base * ACC_W'(DECIMAL_BASE) + ACC_W'(digit);
         stop_new = 1'b0;
      end else begin
         acc_new  = acc_base;
         stop_new = 1'b1;
      end
   end

   // value count from the stored length, by reciprocal multiply
   always_comb begin
      len_less = len_ff - ACC_W'(REPORT_FIXED_LEN);
      x_small  = X_W'(len_less);
      prod     = PROD_W'(x_small) * PROD_W'(RECIP);
      if (len_ff < ACC_W'(REPORT_FIXED_LEN)) begin
         count_in = '0;
      end else if (len_less >= ACC_W'(CAP)) begin
         count_in = CNT_W'(MAX_VALUES);
      end else begin
         count_in = prod[SHIFT +: CNT_W];
      end
   end

   assign rem_dec = rem_ff - 1'b1;

   always_comb begin
      active_in    = active_ff;
      acc_in       = acc_ff;
      stop_in      = stop_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      type_in      = type_ff;
      err_in       = err_ff;
      rem_in       = rem_ff;
      vidx_in      = vidx_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      kind_in      = kind_ff;
      power_in     = power_ff;
      sample_in    = sample_ff;
      sidx_in      = sidx_ff;
      last_in      = last_ff;
      if (q_pop) begin
         if (q_entry.tag == TAG_START) begin
            active_in = 1'b1;
            acc_in    = '0;
            stop_in   = 1'b0;
            addr_in   = '0;
            len_in    = '0;
            type_in   = '0;
            err_in    = '0;
            rem_in    = '0;
            vidx_in   = '0;
         end else if (active_ff) begin
            case (q_entry.tag)
               TAG_ADDR: begin
                  addr_in = {addr_ff[ADDR_W-9:0], q_entry.data};
               end
               TAG_LEN: begin
                  acc_in  = acc_new;
                  stop_in = stop_new;
                  if (q_entry.fin) begin
                     len_in = acc_new;
                  end
               end
               TAG_TYPE: begin
                  acc_in  = acc_new;
                  stop_in = stop_new;
                  if (q_entry.fin) begin
                     type_in = acc_new[TYPE_W-1:0];
                  end
               end
               TAG_ERR: begin
                  acc_in  = acc_new;
                  stop_in = stop_new;
                  if (q_entry.fin) begin
                     err_in = acc_new[ERR_W-1:0];
                  end
               end
               TAG_POW: begin
                  acc_in  = acc_new;
                  stop_in = stop_new;
                  if (q_entry.fin) begin
                     out_valid_in = 1'b1;
                     kind_in      = KIND_HEADER;
                     power_in     = acc_new[POWER_W-1:0];
                     sample_in    = '0;
                     sidx_in      = '0;
                     last_in      = (count_ff == '0);
                     vidx_in      = '0;
                     rem_in       = count_ff;
                     active_in    = (count_ff != '0);
                  end
               end
               TAG_VAL: begin
                  acc_in  = acc_new;
                  stop_in = stop_new;
                  if (q_entry.fin) begin
                     out_valid_in = 1'b1;
                     kind_in      = KIND_VALUE;
                     power_in     = '0;
                     sample_in    = acc_new;
                     sidx_in      = vidx_ff;
                     last_in      = (rem_dec == '0);
                     rem_in       = rem_dec;
                     vidx_in      = vidx_ff + 1'b1;
                     active_in    = (rem_dec != '0);
                  end
               end
               default: begin
                  active_in = active_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         acc_ff       <= '0;
         stop_ff      <= 1'b0;
         addr_ff      <= '0;
         len_ff       <= '0;
         type_ff      <= '0;
         err_ff       <= '0;
         rem_ff       <= '0;
         vidx_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         acc_ff       <= acc_in;
         stop_ff      <= stop_in;
         addr_ff      <= addr_in;
         len_ff       <= len_in;
         type_ff      <= type_in;
         err_ff       <= err_in;
         rem_ff       <= rem_in;
         vidx_ff      <= vidx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff  <= count_in;
      kind_ff   <= kind_in;
      power_ff  <= power_in;
      sample_ff <= sample_in;
      sidx_ff   <= sidx_in;
      last_ff   <= last_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.result_kind    = kind_ff;
   assign rsp_ch.sensor_address = addr_ff;
   assign rsp_ch.device_type    = type_ff;
   assign rsp_ch.error_code     = err_ff;
   assign rsp_ch.power_level    = power_ff;
   assign rsp_ch.value_count    = COUNT_W'(count_ff);
   assign rsp_ch.sample_value   = sample_ff;
   assign rsp_ch.sample_index   = sidx_ff;
   assign rsp_ch.last           = last_ff;

endmodule

// ===== hw/rtl/ascii_report_frame_parser.sv =====
// byte-serial parser of fixed-layout ascii sensor reports, one result per field group
// throughput: one byte per cycle sustained as long as each result is taken when shown
// rsp_ch.valid rises once the completing byte has passed through the queue and set the result register
// a waiting result stalls the back; the four-entry queue then holds up to four more tagged bytes
// reset (synchronous, active high) empties the queue and the result register
// and leaves both halves idle until a byte with frame_start is transferred
module ascii_report_frame_parser #(
   parameter int ADDRESS_BYTES = 3,
   parameter int MAX_VALUES    = 16,
   parameter int VALUE_DIGITS  = 4
) (
   input  logic       clock,
   input  logic       reset,
   arfp_req_if.sink   req_ch,
   arfp_rsp_if.source rsp_ch
);
   import arfp_pkg::*;

   // front to queue
   logic      q_push;
   entry_type q_push_entry;
   logic      q_full;

   // queue to back
   logic      q_pop;
   logic      q_empty;
   entry_type q_pop_entry;

   // front: byte position and field tagging, stalls only on a full queue
   arfp_front #(
      .ADDRESS_BYTES (ADDRESS_BYTES),
      .VALUE_DIGITS  (VALUE_DIGITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_push_entry)
   );

   // decouples the byte stream from output stalls
   arfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .pop_entry  (q_pop_entry)
   );

   // back: decimal fields, value counting and the result register
   arfp_back #(
      .MAX_VALUES   (MAX_VALUES),
      .VALUE_DIGITS (VALUE_DIGITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_entry (q_pop_entry),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

// ===== hw/rtl/arfp_checker.sv =====
// port-level checks of the report frame parser and their bind
`include "ascii_report_frame_parser_macros.svh"

module arfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        result_kind,
   input logic [23:0] sensor_address,
   input logic [6:0]  device_type,
   input logic [6:0]  error_code,
   input logic [7:0]  power_level,
   input logic [4:0]  value_count,
   input logic [13:0] sample_value,
   input logic [3:0]  sample_index,
   input logic        last
);
   import arfp_pkg::*;

   logic [70:0] rsp_payload;
   logic        header_shown, value_shown, sample_clear;

   assign rsp_payload  = {result_kind, sensor_address, device_type, error_code, power_level,
                          value_count, sample_value, sample_index, last};
   assign header_shown = rsp_valid && (result_kind == KIND_HEADER);
   assign value_shown  = rsp_valid && (result_kind == KIND_VALUE);
   assign sample_clear = (sample_value == '0) && (sample_index == '0);

   `ARFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ARFP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload))
   `ARFP_ASSERT_IMPLY(a_header_no_sample, clock, reset, header_shown, sample_clear)
   `ARFP_ASSERT_IMPLY(a_value_no_power, clock, reset, value_shown, power_level == '0)

endmodule

bind ascii_report_frame_parser arfp_checker u_arfp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .result_kind    (rsp_ch.result_kind),
   .sensor_address (rsp_ch.sensor_address),
   .device_type    (rsp_ch.device_type),
   .error_code     (rsp_ch.error_code),
   .power_level    (rsp_ch.power_level),
   .value_count    (rsp_ch.value_count),
   .sample_value   (rsp_ch.sample_value),
   .sample_index   (rsp_ch.sample_index),
   .last           (rsp_ch.last)
);
